FILE: src/mhs_pkg.sv
// Shared types and constants for the streaming MurmurHash2 core.
// No dependencies; the files that use it refer to this package by scoped names.
package mhs_pkg;

  localparam int LENGTH_BITS = 16;
  localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int          MIX_SHIFT   = 24;
  localparam int          FIN_SHIFT_A = 13;
  localparam int          FIN_SHIFT_B = 15;
  localparam logic [31:0] SEED_RESET  = 32'h9747b28c;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // One command per item that starts a message, completes a word or ends a message.
  typedef struct packed {
    logic        start;
    logic [31:0] init_hash;
    logic        has_word;
    logic [31:0] word;
    logic        finish;
    logic        tail_nz;
    logic [23:0] tail;
  } cmd_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_K1,
    BS_K2,
    BS_HM,
    BS_TM,
    BS_FM,
    BS_OUT
  } back_state_t;

endpackage

FILE: src/mhs_in_if.sv
// Input byte request channel of the MurmurHash2 core.
// Depends on nothing; payload widths follow the message byte stream format.
interface mhs_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] msg_length;
  logic        last;

  modport source (output valid, output data_byte, output msg_length, output last,
                  input ready);
  modport sink (input valid, input data_byte, input msg_length, input last,
                output ready);
endinterface

FILE: src/mhs_out_if.sv
// Result request channel of the MurmurHash2 core: one finalized hash per message.
// Depends on nothing.
interface mhs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

FILE: src/murmur2_hash_stream_core.sv
// Streaming 32-bit MurmurHash2 core.
// in_ch takes one message byte per request; the first request of a message also
// carries msg_length (mixed into the seed), and the request with last set ends
// the message. out_ch delivers one hash_value per message.
// cfg_we/cfg_wdata write the seed; write it only while no message is in flight.
// The front end takes a byte every cycle while the 4-entry command queue has
// room. The back end spends its idle step on each command, plus K1, K2 and HM
// per complete word (one multiplier step each) and TM (tail only), FM and OUT
// to finish a message, so a steady stream runs at about one byte per cycle.
// With the back end idle, a hash is valid once its last command has passed the
// queue and the finishing steps, held in the output register; that register lets
// the back end take the next command while the result waits.
// Reset (rst, synchronous) empties the queue, drops any partial message and any
// pending result, and loads the seed with 0x9747b28c.
// When out_ch stalls, the back end holds in its output step; once the queue
// fills, in_ch.ready drops.
module murmur2_hash_stream_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  mhs_in_if.sink      in_ch,
  mhs_out_if.source   out_ch
);

  logic                          q_push;
  logic                          q_pop;
  logic                          q_full;
  logic                          q_valid;
  mhs_pkg::cmd_t                 q_cmd;
  mhs_pkg::cmd_t                 q_head;
  logic [mhs_pkg::CMD_CNT_W-1:0] q_level;

  mhs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  mhs_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_valid),
    .head     (q_head),
    .level    (q_level)
  );

  mhs_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  a_level_bounded: assert property (@(posedge clk) disable iff (rst)
    q_level <= mhs_pkg::CMD_CNT_W'(mhs_pkg::CMD_DEPTH))
    else $error("command queue level out of range");

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_pop_only_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule

FILE: src/mhs_front.sv
// Front end: accepts bytes, packs little-endian words and issues hash commands.
// Depends on mhs_pkg and mhs_in_if; holds the seed register.
module mhs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata,
  mhs_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output mhs_pkg::cmd_t q_cmd
);

  logic [31:0] seed;
  logic        in_msg;
  logic [1:0]  byte_pos;
  logic [23:0] word_bytes;

  logic        accept;
  logic        first;
  logic        absorb;
  logic        full_word;
  logic [31:0] len32;
  logic [1:0]  bp_cur;
  logic [23:0] wb_cur;
  logic [23:0] wb_ins;
  logic [1:0]  byte_pos_next;
  logic [23:0] word_bytes_next;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    first     = !in_msg;
    len32     = 32'(in_ch.msg_length) & mhs_pkg::LEN_MASK;
    // zero-length first item carries no byte
    absorb    = !first || (len32 != 32'd0);
    bp_cur    = first ? 2'd0 : byte_pos;
    wb_cur    = first ? 24'd0 : word_bytes;
    full_word = absorb && (bp_cur == 2'd3);
    wb_ins    = wb_cur | (24'(in_ch.data_byte) << {bp_cur, 3'b000});
    if (full_word) begin
      byte_pos_next   = 2'd0;
      word_bytes_next = 24'd0;
    end else if (absorb) begin
      byte_pos_next   = bp_cur + 2'd1;
      word_bytes_next = wb_ins;
    end else begin
      byte_pos_next   = bp_cur;
      word_bytes_next = wb_cur;
    end

    q_cmd.start     = first;
    q_cmd.init_hash = seed ^ len32;
    q_cmd.has_word  = full_word;
    q_cmd.word      = {in_ch.data_byte, wb_cur};
    q_cmd.finish    = in_ch.last;
    q_cmd.tail_nz   = (byte_pos_next != 2'd0);
    q_cmd.tail      = word_bytes_next;
    q_push          = accept && (first || full_word || in_ch.last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed       <= mhs_pkg::SEED_RESET;
      in_msg     <= 1'b0;
      byte_pos   <= 2'd0;
      word_bytes <= 24'd0;
    end else begin
      if (cfg_we) begin
        seed <= cfg_wdata;
      end
      if (accept) begin
        if (in_ch.last) begin
          in_msg     <= 1'b0;
          byte_pos   <= 2'd0;
          word_bytes <= 24'd0;
        end else begin
          in_msg     <= 1'b1;
          byte_pos   <= byte_pos_next;
          word_bytes <= word_bytes_next;
        end
      end
    end
  end

endmodule

FILE: src/mhs_cmd_fifo.sv
// Small command queue between front end and hash back end.
// Depends on mhs_pkg for the command type and depth.
module mhs_cmd_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  mhs_pkg::cmd_t                 push_cmd,
  input  logic                          pop,
  output logic                          full,
  output logic                          not_empty,
  output mhs_pkg::cmd_t                 head,
  output logic [mhs_pkg::CMD_CNT_W-1:0] level
);

  mhs_pkg::cmd_t                 entries [mhs_pkg::CMD_DEPTH];
  logic [mhs_pkg::CMD_PTR_W-1:0] wr_ptr;
  logic [mhs_pkg::CMD_PTR_W-1:0] rd_ptr;
  logic [mhs_pkg::CMD_CNT_W-1:0] count;

  assign full      = (count == mhs_pkg::CMD_CNT_W'(mhs_pkg::CMD_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign level     = count;

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + mhs_pkg::CMD_CNT_W'(push && !full)
                     - mhs_pkg::CMD_CNT_W'(pop && not_empty);
    end
  end

endmodule

FILE: src/mhs_back.sv
// Back end: runs queued commands through one shared 32x32 multiplier, one step
// per cycle unless held in its output step by a stalled out_ch, and holds the finalized hash in an output register.
// Depends on mhs_pkg and mhs_out_if.
module mhs_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  mhs_pkg::cmd_t q_head,
  output logic          q_pop,
  mhs_out_if.source     out_ch
);

  mhs_pkg::back_state_t state;
  mhs_pkg::back_state_t state_next;

  logic [31:0] h;
  logic [31:0] k;
  logic        fin;
  logic        tail_nz;
  logic [23:0] tail;
  logic        out_valid;
  logic [31:0] out_hash;

  logic [31:0] mul_a;
  logic [31:0] prod;
  logic        out_load;

  assign prod = mul_a * mhs_pkg::MIX_MUL;

  always_comb begin
    state_next = state;
    case (state)
      mhs_pkg::BS_IDLE: begin
        if (q_valid) begin
          if (q_head.has_word) begin
            state_next = mhs_pkg::BS_K1;
          end else if (q_head.finish) begin
            state_next = q_head.tail_nz ? mhs_pkg::BS_TM : mhs_pkg::BS_FM;
          end
        end
      end
      mhs_pkg::BS_K1: state_next = mhs_pkg::BS_K2;
      mhs_pkg::BS_K2: state_next = mhs_pkg::BS_HM;
      mhs_pkg::BS_HM: begin
        if (fin) begin
          state_next = tail_nz ? mhs_pkg::BS_TM : mhs_pkg::BS_FM;
        end else begin
          state_next = mhs_pkg::BS_IDLE;
        end
      end
      mhs_pkg::BS_TM: state_next = mhs_pkg::BS_FM;
      mhs_pkg::BS_FM: state_next = mhs_pkg::BS_OUT;
      mhs_pkg::BS_OUT: begin
        if (!out_valid || out_ch.ready) begin
          state_next = mhs_pkg::BS_IDLE;
        end
      end
      default: state_next = mhs_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    mul_a    = h;
    case (state)
      mhs_pkg::BS_IDLE: q_pop = q_valid;
      mhs_pkg::BS_K1:   mul_a = k;
      mhs_pkg::BS_K2:   mul_a = k ^ (k >> mhs_pkg::MIX_SHIFT);
      mhs_pkg::BS_HM:   mul_a = h;
      mhs_pkg::BS_TM:   mul_a = h ^ {8'd0, tail};
      mhs_pkg::BS_FM:   mul_a = h ^ (h >> mhs_pkg::FIN_SHIFT_A);
      mhs_pkg::BS_OUT:  out_load = !out_valid || out_ch.ready;
      default:          mul_a = h;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      mhs_pkg::BS_IDLE: begin
        if (q_valid) begin
          if (q_head.start) begin
            h <= q_head.init_hash;
          end
          k       <= q_head.word;
          fin     <= q_head.finish;
          tail_nz <= q_head.tail_nz;
          tail    <= q_head.tail;
        end
      end
      mhs_pkg::BS_K1: k <= prod;
      mhs_pkg::BS_K2: k <= prod;
      mhs_pkg::BS_HM: h <= prod ^ k;
      mhs_pkg::BS_TM: h <= prod;
      mhs_pkg::BS_FM: h <= prod;
      default: ;
    endcase
    if (out_load) begin
      out_hash <= h ^ (h >> mhs_pkg::FIN_SHIFT_B);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mhs_pkg::BS_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.hash_value = out_hash;

endmodule

FILE: tb/mhs_hash_checker.sv
// Passive checker for the streaming MurmurHash2 core: watches the byte and result channels.
// Depends on mhs_pkg and the mhs_in_if / mhs_out_if interfaces.
// Predicts each message hash and compares it with the delivered hash_value.
module mhs_hash_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  mhs_in_if           in_mon,
  mhs_out_if          out_mon,
  output int          fail_count,
  output int          hashes_due
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] seed;
  logic [31:0] acc_hash;
  logic [23:0] tail_bytes;
  logic [1:0]  tail_cnt;
  logic        in_msg;
  logic [31:0] expected_hashes[$];
  int          fails = 0;
  int          due = 0;

  assign fail_count = fails;
  assign hashes_due = due;

  // Buffer one byte; the fourth byte completes a little-endian word that gets mixed in.
  task automatic fold_byte(input logic [7:0] b);
    logic [31:0] k;
    if (tail_cnt == 2'd3) begin
      k = {b, tail_bytes} * mhs_pkg::MIX_MUL;
      k = k ^ (k >> mhs_pkg::MIX_SHIFT);
      k = k * mhs_pkg::MIX_MUL;
      acc_hash = (acc_hash * mhs_pkg::MIX_MUL) ^ k;
      tail_bytes = '0;
      tail_cnt = '0;
    end else begin
      tail_bytes = tail_bytes | (24'(b) << (8 * tail_cnt));
      tail_cnt = tail_cnt + 2'd1;
    end
  endtask

  always @(posedge clk) begin : watch
    logic [31:0] h;
    logic [15:0] len;
    if (rst) begin
      seed = mhs_pkg::SEED_RESET;
      acc_hash = '0;
      tail_bytes = '0;
      tail_cnt = '0;
      in_msg = 1'b0;
      expected_hashes.delete();
      due = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_hashes.size() == 0) begin
          $error("hash_value: expected none, actual %08h", out_mon.hash_value);
          fails++;
        end else begin
          h = expected_hashes.pop_front();
          due--;
          if (out_mon.hash_value !== h) begin
            $error("hash_value: expected %08h, actual %08h", h, out_mon.hash_value);
            fails++;
          end
        end
      end
      if (cfg_we)
        seed = cfg_wdata;
      if (in_mon.valid && in_mon.ready) begin
        len = in_mon.msg_length & 16'(mhs_pkg::LEN_MASK);
        if (!in_msg) begin
          acc_hash = seed ^ {16'd0, len};
          tail_bytes = '0;
          tail_cnt = '0;
          in_msg = 1'b1;
          // zero length: the byte of the opening request is dropped
          if (len != 16'd0)
            fold_byte(in_mon.data_byte);
        end else begin
          fold_byte(in_mon.data_byte);
        end
        if (in_mon.last) begin
          h = acc_hash;
          if (tail_cnt != 2'd0) begin
            h = h ^ {8'd0, tail_bytes};
            h = h * mhs_pkg::MIX_MUL;
          end
          h = h ^ (h >> mhs_pkg::FIN_SHIFT_A);
          h = h * mhs_pkg::MIX_MUL;
          h = h ^ (h >> mhs_pkg::FIN_SHIFT_B);
          expected_hashes.push_back(h);
          due++;
          acc_hash = '0;
          tail_bytes = '0;
          tail_cnt = '0;
          in_msg = 1'b0;
        end
      end
    end
  end

endmodule

FILE: tb/tb_murmur2_hash_stream_core.sv
// Top of the MurmurHash2 core testbench: clock, reset, byte requests, result stalls, verdict.
// Depends on mhs_pkg, mhs_in_if, mhs_out_if, murmur2_hash_stream_core and mhs_hash_checker.
module tb_murmur2_hash_stream_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  int          fail_count;
  int          hashes_due;
  int          sent;
  int          burst_left;
  bit          steady_send;
  bit          hold_req;

  mhs_in_if  in_ch ();
  mhs_out_if out_ch ();

  always #4 clk = ~clk;

  murmur2_hash_stream_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  mhs_hash_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .hashes_due (hashes_due)
  );

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side: stall pattern changes at random intervals; a long hold-off on request.
  initial begin : sink_side
    int mode;
    int left;
    int held;
    bit hold_done;
    out_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        for (held = 0; held < 300; held++)
          @(negedge clk);
        hold_done = 1'b1;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(40, 400);
      end
      left--;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ((left % 8) < 3);
      endcase
    end
  end

  // One byte request; bursts of random length separated by random gaps unless steady.
  task automatic send_item(input logic [7:0] b, input logic [15:0] len, input logic lst);
    int gap;
    if (!steady_send) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 5);
        repeat (gap) begin
          @(negedge clk);
          in_ch.valid <= 1'b0;
        end
      end
      burst_left--;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.msg_length <= len;
    in_ch.last       <= lst;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    sent++;
  endtask

  // Length is only sampled on the first request; later ones carry junk there.
  task automatic send_msg(input int nbytes, input logic [15:0] len);
    for (int i = 0; i < nbytes; i++)
      send_item(8'($urandom), (i == 0) ? len : 16'($urandom), i == nbytes - 1);
  endtask

  // Wait for every outstanding hash or a timeout, then allow for back-end latency.
  task automatic drain();
    int waited;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    waited = 0;
    while (hashes_due != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (12) @(negedge clk);
  endtask

  task automatic write_seed(input logic [31:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_phase(input int n_items);
    int stop;
    int nb;
    int pick;
    logic [15:0] len;
    stop = sent + n_items;
    while (sent < stop) begin
      pick = $urandom_range(0, 99);
      nb = (pick < 85) ? $urandom_range(1, 12) : $urandom_range(13, 48);
      pick = $urandom_range(0, 99);
      if (pick < 70)
        len = 16'(nb);
      else if (pick < 82)
        len = 16'($urandom);
      else if (pick < 92)
        len = 16'd0;
      else
        len = 16'hFFFF;
      if ($urandom_range(0, 24) == 0) begin
        nb = 1;
        len = 16'd0;
      end
      if ($urandom_range(0, 19) == 0)
        steady_send = !steady_send;
      send_msg(nb, len);
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.msg_length = '0;
    in_ch.last       = 1'b0;
    hold_req    = 1'b0;
    steady_send = 1'b0;
    burst_left  = 0;
    sent        = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, reset seed
    send_item(8'hFF, 16'd0, 1'b1);      // empty message, byte dropped
    send_item(8'h00, 16'd1, 1'b1);
    send_item(8'hFF, 16'hFFFF, 1'b1);
    send_item(8'h01, 16'd3, 1'b0);      // three tail bytes
    send_item(8'h80, 16'd0, 1'b0);
    send_item(8'hFF, 16'd0, 1'b1);
    send_item(8'hA5, 16'd4, 1'b0);      // exactly one word, no tail
    send_item(8'h5A, 16'd0, 1'b0);
    send_item(8'hFF, 16'd0, 1'b0);
    send_item(8'h00, 16'd0, 1'b1);
    send_item(8'h11, 16'd5, 1'b0);      // word plus one tail byte
    send_item(8'h22, 16'd0, 1'b0);
    send_item(8'h33, 16'd0, 1'b0);
    send_item(8'h44, 16'd0, 1'b0);
    send_item(8'hFE, 16'd0, 1'b1);
    send_item(8'hAA, 16'd0, 1'b0);      // zero length, not last: later bytes still count
    send_item(8'h55, 16'hFFFF, 1'b0);
    send_item(8'hC3, 16'd0, 1'b1);
    send_item(8'h7F, 16'h8000, 1'b0);   // stated length disagrees with byte count
    send_item(8'hFE, 16'h0001, 1'b1);
    drain();

    write_seed(32'h0000_0000);
    random_phase(250);
    drain();

    // output held off long enough for the core to back up into in_ch
    write_seed(32'hFFFF_FFFF);
    hold_req = 1'b1;
    random_phase(250);
    drain();

    write_seed(32'($urandom));
    random_phase(150);
    drain();
    random_phase(150);
    drain();

    write_seed(mhs_pkg::SEED_RESET);
    random_phase(250);
    drain();

    write_seed(32'($urandom));
    random_phase(250);
    drain();

    if (fail_count == 0 && hashes_due == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
src/mhs_pkg.sv
src/mhs_in_if.sv
src/mhs_out_if.sv
src/mhs_front.sv
src/mhs_cmd_fifo.sv
src/mhs_back.sv
src/murmur2_hash_stream_core.sv
tb/mhs_hash_checker.sv
tb/tb_murmur2_hash_stream_core.sv
